[rtl/stsd_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted table package
// Shared types, codes and sizes of the sorted table block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stsd_pkg;

  // Table size and derived widths.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths of the words on the channels.
  localparam int FUNC_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Depth of the request queue between front and back.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Operation codes as they arrive on the input channel.
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

  // Decoded operation carried through the queue.
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_SEARCH,
    OP_DELETE,
    OP_NOP
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // One classified request.
  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  // Head of the request queue as seen by the back end.
  typedef struct packed {
    logic valid;
    req_t req;
  } q_out_t;

endpackage

[rtl/sorted_table_insert_search_delete.sv]
// ----------------------------------------------------------------------------
// Sorted table with insert, search and delete
// Keeps up to DEPTH signed 32-bit values in ascending order, duplicates
// allowed. Each request word returns one result word with a status and the
// entry count after the request. A two-entry request queue lets new words
// be accepted while the table is busy or a result waits to be taken. The
// table sits in a single RAM with one write and one registered read port,
// and the back end visits one entry per cycle: an insert into a table that
// already holds entries walks down past the entries larger than the value,
// a search scans up to the entry where the scan stops, a delete does the
// same and then moves the later entries down, and an insert into an empty
// or a full table, a search or delete on an empty table or an unused code
// goes straight to its result. A word waits in the queue for the words
// ahead of it while the back end is busy or an earlier result waits to be
// taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_table_insert_search_delete (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [stsd_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [stsd_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [stsd_pkg::STATUS_W-1:0]       out_status,
  output logic [stsd_pkg::COUNT_W-1:0]        out_entry_count
);
  import stsd_pkg::*;

  q_out_t q;
  logic   pop;

  // Front end: decode and queue request words.
  stsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_func),
    .in_value (in_value),
    .pop      (pop),
    .q        (q)
  );

  // Back end: table operations and result register.
  stsd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q               (q),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule

[rtl/stsd_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/stsd_front.sv]
// ----------------------------------------------------------------------------
// Sorted table front end
// Accepts request words, decodes the operation and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stsd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [stsd_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [stsd_pkg::VALUE_W-1:0] in_value,
  input  logic                                pop,
  output stsd_pkg::q_out_t                    q
);
  import stsd_pkg::*;

  req_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] q_cnt_r, q_cnt_nxt;
  logic              push;
  logic              do_pop;
  req_t              dec_req;

  // Decode the operation code of the incoming word.
  always_comb begin
    dec_req.value = in_value;
    unique case (in_func)
      FUNC_INSERT: dec_req.op = OP_INSERT;
      FUNC_SEARCH: dec_req.op = OP_SEARCH;
      FUNC_DELETE: dec_req.op = OP_DELETE;
      default:     dec_req.op = OP_NOP;
    endcase
  end

  // Queue handshake: stall while every slot is taken.
  assign in_stall = (q_cnt_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (q_cnt_r != '0);

  assign q.valid = (q_cnt_r != '0);
  assign q.req   = q_mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    q_cnt_nxt  = q_cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !do_pop) begin
      q_cnt_nxt = q_cnt_r + QCNT_W'(1);
    end else if (do_pop && !push) begin
      q_cnt_nxt = q_cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec_req;
    end
  end

`ifndef NO_ASSERTIONS
  // The fill count never passes the number of slots.
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCNT_W'(QDEPTH))
    else $error("request queue over capacity");
`endif

endmodule

[rtl/stsd_back.sv]
// ----------------------------------------------------------------------------
// Sorted table back end
// Runs each queued request against the table RAM and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stsd_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  stsd_pkg::q_out_t                     q,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [stsd_pkg::STATUS_W-1:0]        out_status,
  output logic [stsd_pkg::COUNT_W-1:0]         out_entry_count
);
  import stsd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_SCAN_CMP,
    S_DEL_MV,
    S_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  op_t                       op_r, op_nxt;
  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic [IDX_W-1:0]          ptr_r, ptr_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  status_t                   status_r, status_nxt;
  logic                      out_valid_r, out_valid_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]        out_count_r, out_count_nxt;

  logic                      we;
  logic [IDX_W-1:0]          waddr;
  logic [VALUE_W-1:0]        wdata;
  logic [IDX_W-1:0]          raddr;
  logic [VALUE_W-1:0]        rdata;
  logic signed [VALUE_W-1:0] rd_s;

  logic [IDX_W-1:0]          ptr_inc;
  logic [IDX_W-1:0]          ptr_dec;
  logic [CNT_W-1:0]          ptr_ext1;
  logic [CNT_W-1:0]          ptr_ext2;
  logic [CNT_W-1:0]          cnt_dec;
  logic                      out_free;

  // Table storage.
  stsd_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_s     = $signed(rdata);
  assign ptr_inc  = ptr_r + IDX_W'(1);
  assign ptr_dec  = ptr_r - IDX_W'(1);
  assign ptr_ext1 = CNT_W'(ptr_r) + CNT_W'(1);
  assign ptr_ext2 = CNT_W'(ptr_r) + CNT_W'(2);
  assign cnt_dec  = cnt_r - CNT_W'(1);
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer: an insert walks down from the top entry shifting larger
  // entries up; search and delete walk up from entry zero, and a delete
  // then moves the later entries down one place.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    value_nxt      = value_r;
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    we             = 1'b0;
    waddr          = ptr_r;
    wdata          = value_r;
    raddr          = ptr_r;
    pop            = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (q.valid) begin
          pop       = 1'b1;
          op_nxt    = q.req.op;
          value_nxt = q.req.value;
          unique case (q.req.op)
            OP_INSERT: begin
              if (cnt_r == CNT_W'(DEPTH)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else if (cnt_r == '0) begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = q.req.value;
                cnt_nxt    = cnt_r + CNT_W'(1);
                status_nxt = ST_INSERTED;
                state_nxt  = S_DONE;
              end else begin
                raddr     = cnt_dec[IDX_W-1:0];
                ptr_nxt   = cnt_dec[IDX_W-1:0];
                state_nxt = S_INS_CMP;
              end
            end
            OP_SEARCH, OP_DELETE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_NOT_FOUND;
                state_nxt  = S_DONE;
              end else begin
                raddr     = '0;
                ptr_nxt   = '0;
                state_nxt = S_SCAN_CMP;
              end
            end
            default: begin
              status_nxt = ST_NOT_FOUND;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      // Entry at ptr is in rdata; larger ones move up one place.
      S_INS_CMP: begin
        we    = 1'b1;
        waddr = ptr_inc;
        if (rd_s > value_r) begin
          wdata = rdata;
          if (ptr_r == '0) begin
            state_nxt = S_INS_PUT;
          end else begin
            raddr   = ptr_dec;
            ptr_nxt = ptr_dec;
          end
        end else begin
          wdata      = value_r;
          cnt_nxt    = cnt_r + CNT_W'(1);
          status_nxt = ST_INSERTED;
          state_nxt  = S_DONE;
        end
      end

      // Every entry was larger: the new value goes to the bottom.
      S_INS_PUT: begin
        we         = 1'b1;
        waddr      = '0;
        wdata      = value_r;
        cnt_nxt    = cnt_r + CNT_W'(1);
        status_nxt = ST_INSERTED;
        state_nxt  = S_DONE;
      end

      // Look for the first equal entry, stopping at a larger one.
      S_SCAN_CMP: begin
        if (rd_s == value_r) begin
          if (op_r == OP_DELETE) begin
            if (ptr_ext1 == cnt_r) begin
              cnt_nxt    = cnt_dec;
              status_nxt = ST_FOUND;
              state_nxt  = S_DONE;
            end else begin
              raddr     = ptr_inc;
              state_nxt = S_DEL_MV;
            end
          end else begin
            status_nxt = ST_FOUND;
            state_nxt  = S_DONE;
          end
        end else if (rd_s > value_r || ptr_ext1 == cnt_r) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          raddr   = ptr_inc;
          ptr_nxt = ptr_inc;
        end
      end

      // Entry at ptr+1 is in rdata; it moves down to ptr.
      S_DEL_MV: begin
        we    = 1'b1;
        waddr = ptr_r;
        wdata = rdata;
        if (ptr_ext2 == cnt_r) begin
          cnt_nxt    = cnt_dec;
          status_nxt = ST_FOUND;
          state_nxt  = S_DONE;
        end else begin
          raddr   = ptr_ext2[IDX_W-1:0];
          ptr_nxt = ptr_inc;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = COUNT_W'(cnt_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    value_r      <= value_nxt;
    ptr_r        <= ptr_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

`ifndef NO_ASSERTIONS
  // The entry count stays within the table.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count beyond table depth");

  // One request changes the entry count by at most one.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + CNT_W'(1) ||
                      cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("entry count jumped");

  // A scan never reads past the held entries.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_CMP || state_r == S_INS_CMP) |-> CNT_W'(ptr_r) < cnt_r)
    else $error("table scan beyond held entries");

  // A dropped insert reports a full table.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> out_count_r == COUNT_W'(DEPTH))
    else $error("full status with a table that is not full");
`endif

endmodule
